@@ hdl/custom_order_sorted_check_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the custom-order sorted check
// Shared property forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CUSTOM_ORDER_SORTED_CHECK_CORE_MACROS_SVH
`define CUSTOM_ORDER_SORTED_CHECK_CORE_MACROS_SVH

// Same-cycle implication.
`define COSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define COSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/cosc_pkg.sv @@
// ----------------------------------------------------------------------------
// cosc_pkg
// Types, constants and the rank lookup of the custom-order sorted check.
// ----------------------------------------------------------------------------
package cosc_pkg;

    localparam int NUM_LETTERS      = 26;
    localparam int RANK_W           = 5;
    localparam int DEF_MAX_WORD_LEN = 32;
    localparam int RANK_LOW_W       = 60;
    localparam int RANK_HIGH_W      = 10;
    localparam int RANK_ALL_W       = 2 * RANK_LOW_W + RANK_HIGH_W;
    localparam int CFG_INDEX_W      = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_RANK_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANK_MID  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANK_HIGH = 2'd2;

    typedef enum logic [1:0] {
        DEC_UNDECIDED = 2'd0,
        DEC_GREATER   = 2'd1,
        DEC_LESS      = 2'd2
    } decision_t;

    typedef struct packed {
        logic [4:0] letter;
        logic       empty_word;
        logic       word_end;
        logic       list_end;
    } in_item_t;

    typedef struct packed {
        logic sorted;
        logic word_too_long;
    } out_item_t;

    // Item as it sits in the compare stage
    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              empty_word;
        logic              word_end;
        logic              list_end;
        logic              fwd_hit;
        logic [RANK_W-1:0] fwd_rank;
    } cmp_item_t;

    // Letters past the alphabet rank as zero
    function automatic logic [RANK_W-1:0] rank_of(input logic [4:0] letter,
                                                  input logic [RANK_ALL_W-1:0] rank_bits);
        logic [RANK_W-1:0] r;
        r = '0;
        if (int'(letter) < NUM_LETTERS) begin
            r = rank_bits[int'(letter) * RANK_W +: RANK_W];
        end
        return r;
    endfunction

endpackage

@@ hdl/cosc_ram.sv @@
// ----------------------------------------------------------------------------
// cosc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cosc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/cosc_rank.sv @@
// ----------------------------------------------------------------------------
// cosc_rank
// Rank table registers and letter-to-rank lookup.
// ----------------------------------------------------------------------------
module cosc_rank import cosc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [RANK_LOW_W-1:0]  cfg_data,
    input  logic [4:0]             letter,
    output logic [RANK_W-1:0]      rank
);

    logic [RANK_LOW_W-1:0]  rank_low_reg;
    logic [RANK_LOW_W-1:0]  rank_mid_reg;
    logic [RANK_HIGH_W-1:0] rank_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_low_reg  <= '0;
            rank_mid_reg  <= '0;
            rank_high_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_RANK_LOW:  rank_low_reg  <= cfg_data;
                CFG_RANK_MID:  rank_mid_reg  <= cfg_data;
                CFG_RANK_HIGH: rank_high_reg <= cfg_data[RANK_HIGH_W-1:0];
                default: ;
            endcase
        end
    end

    assign rank = rank_of(letter, {rank_high_reg, rank_mid_reg, rank_low_reg});

endmodule

@@ hdl/cosc_list.sv @@
// ----------------------------------------------------------------------------
// cosc_list
// Compare stage: pair decision, word bookkeeping and list verdict.
// ----------------------------------------------------------------------------
module cosc_list import cosc_pkg::*; #(
    parameter int MAX_WORD_LEN = DEF_MAX_WORD_LEN,
    parameter int POS_W        = $clog2(MAX_WORD_LEN + 1),
    parameter int AW           = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  cmp_item_t         item,
    input  logic [POS_W-1:0]  pos,
    input  logic [RANK_W-1:0] ram_rank,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [RANK_W-1:0] wr_data,
    output logic              emit,
    output out_item_t         result
);

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_WORD_LEN);

    decision_t        dec_reg, dec_next;
    logic [POS_W-1:0] prev_len_reg;
    logic             have_prev_reg;
    logic             sorted_reg, sorted_next;
    logic             ovf_reg, ovf_next;

    logic              in_range;
    logic              take;
    logic              wend;
    logic [RANK_W-1:0] prev_rank;
    logic [POS_W-1:0]  pos_next;

    assign in_range  = (pos < MAX_POS);
    assign take      = !item.empty_word && in_range;
    assign wend      = item.word_end || item.empty_word;
    assign prev_rank = item.fwd_hit ? item.fwd_rank : ram_rank;
    assign pos_next  = take ? POS_W'(pos + 1'b1) : pos;

    always_comb begin
        dec_next = dec_reg;
        if (take && have_prev_reg && dec_reg == DEC_UNDECIDED) begin
            if (pos < prev_len_reg) begin
                if (item.rank > prev_rank) begin
                    dec_next = DEC_GREATER;
                end else if (item.rank < prev_rank) begin
                    dec_next = DEC_LESS;
                end
            end else begin
                dec_next = DEC_GREATER;
            end
        end
    end

    assign ovf_next    = ovf_reg || (!item.empty_word && !in_range);
    assign sorted_next = sorted_reg && !(have_prev_reg && (dec_next == DEC_LESS ||
                         (dec_next == DEC_UNDECIDED && pos_next < prev_len_reg)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_reg       <= DEC_UNDECIDED;
            prev_len_reg  <= '0;
            have_prev_reg <= 1'b0;
            sorted_reg    <= 1'b1;
            ovf_reg       <= 1'b0;
        end else if (fire) begin
            if (wend && item.list_end) begin
                dec_reg       <= DEC_UNDECIDED;
                prev_len_reg  <= '0;
                have_prev_reg <= 1'b0;
                sorted_reg    <= 1'b1;
                ovf_reg       <= 1'b0;
            end else if (wend) begin
                dec_reg       <= DEC_UNDECIDED;
                prev_len_reg  <= pos_next;
                have_prev_reg <= 1'b1;
                sorted_reg    <= sorted_next;
                ovf_reg       <= ovf_next;
            end else begin
                dec_reg <= dec_next;
                ovf_reg <= ovf_next;
            end
        end
    end

    assign wr_en   = fire && take;
    assign wr_addr = pos[AW-1:0];
    assign wr_data = item.rank;

    assign emit                 = wend && item.list_end;
    assign result.sorted        = sorted_next;
    assign result.word_too_long = ovf_next;

endmodule

@@ hdl/custom_order_sorted_check_core.sv @@
// A verdict passes the compare stage and the output register before it is valid.
// Throughput: one letter item per cycle unless stalled; one buffer read at accept,
//   one write in the compare stage, write-to-read forwarding between neighbors.
// Stall: only while a verdict waits in the output register and another arrives.
// Reset (aresetn low, synchronous): ranks zero, list state clear; no buffer sweep.
// ----------------------------------------------------------------------------
// custom_order_sorted_check_core
// Checks that a stream of words is non-decreasing under a configurable
// letter order, one verdict per list.
// ----------------------------------------------------------------------------
module custom_order_sorted_check_core import cosc_pkg::*; #(
    parameter int MAX_WORD_LEN = DEF_MAX_WORD_LEN
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // letter items
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    // verdicts
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    // rank table writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [RANK_LOW_W-1:0]  cfg_data
);

    localparam int               POS_W   = $clog2(MAX_WORD_LEN + 1);
    localparam int               AW      = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_WORD_LEN);

    // ------------------------------------------------------------------
    // Accept stage: letter position counter, rank lookup, buffer read
    // ------------------------------------------------------------------
    logic              s_fire;
    logic [POS_W-1:0]  pos_reg;
    logic [RANK_W-1:0] rank;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [RANK_W-1:0] rd_data;

    // Compare stage
    logic              cmp_valid_reg;
    cmp_item_t         cmp_item_reg;
    logic [POS_W-1:0]  cmp_pos_reg;
    logic              cmp_go;
    logic              cmp_fire;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [RANK_W-1:0] wr_data;
    logic              emit;
    out_item_t         result;

    // Output register
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    assign cfg_ready = 1'b1;

    cosc_rank u_rank (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .letter    (s_data.letter),
        .rank      (rank)
    );

    // The compare stage advances unless it holds a verdict the output
    // register cannot take; the accept stage follows it.
    assign cmp_go   = !emit || !m_valid_reg || m_ready;
    assign cmp_fire = cmp_valid_reg && cmp_go;
    assign s_ready  = !cmp_valid_reg || cmp_go;
    assign s_fire   = s_valid && s_ready;

    // Read the previous word's entry at this letter's position
    assign rd_en   = s_fire && !s_data.empty_word && (pos_reg < MAX_POS);
    assign rd_addr = pos_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (s_fire) begin
            if (s_data.empty_word || s_data.word_end) begin
                pos_reg <= '0;
            end else if (pos_reg < MAX_POS) begin
                pos_reg <= POS_W'(pos_reg + 1'b1);
            end
        end
    end

    cosc_ram #(
        .WIDTH (RANK_W),
        .DEPTH (MAX_WORD_LEN),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // ------------------------------------------------------------------
    // Compare stage registers. A write landing on the entry being read
    // at the same edge is forwarded, since the RAM returns the old data.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_valid_reg <= 1'b0;
        end else if (s_fire) begin
            cmp_valid_reg <= 1'b1;
        end else if (cmp_fire) begin
            cmp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmp_item_reg.rank       <= rank;
            cmp_item_reg.empty_word <= s_data.empty_word;
            cmp_item_reg.word_end   <= s_data.word_end;
            cmp_item_reg.list_end   <= s_data.list_end;
            cmp_item_reg.fwd_hit    <= wr_en && (wr_addr == rd_addr);
            cmp_item_reg.fwd_rank   <= wr_data;
            cmp_pos_reg             <= pos_reg;
        end
    end

    cosc_list #(
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .POS_W        (POS_W),
        .AW           (AW)
    ) u_list (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (cmp_fire),
        .item     (cmp_item_reg),
        .pos      (cmp_pos_reg),
        .ram_rank (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .emit     (emit),
        .result   (result)
    );

    // ------------------------------------------------------------------
    // Output register: load a verdict, hold it until taken
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmp_fire && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmp_fire && emit) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ hdl/cosc_checker.sv @@
// ----------------------------------------------------------------------------
// cosc_checker
// Port-level assertions for the custom-order sorted check, bound to the core.
// ----------------------------------------------------------------------------
`include "custom_order_sorted_check_core_macros.svh"

module cosc_checker import cosc_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    logic list_done;

    assign list_done = s_valid && s_ready && s_data.list_end &&
                       (s_data.word_end || s_data.empty_word);

    `COSC_ASSERT_NEXT(a_m_valid_hold, m_valid && !m_ready, m_valid, "verdict dropped while stalled")
    `COSC_ASSERT_NEXT(a_m_data_hold, m_valid && !m_ready, $stable(m_data), "verdict changed while stalled")
    `COSC_ASSERT_NOW(a_ready_when_out_empty, !m_valid, s_ready, "input stalled with empty output")
    `COSC_ASSERT_NOW(a_verdict_from_list_end, $rose(m_valid), $past(list_done, 2), "verdict without list end")

endmodule

bind custom_order_sorted_check_core cosc_checker u_cosc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
